// ===== design/rpz_pkg.sv =====
// Shared types and constants for the rotate/project/z-buffer plot unit.
// No dependencies; used by every module of the block except rpz_ram.
`default_nettype none
package rpz_pkg;

  localparam int CELL_FIELD_W = 13;
  localparam int DEPTH_W      = 24;
  localparam int GLYPH_W      = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int CNT_W        = 5;

  localparam int ROT_STEPS  = 16;
  localparam int DIV_BITS   = 24;
  localparam int PROJ_STEPS = 3;

  // request modes
  localparam logic [1:0] MODE_PLOT  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_HIDDEN = 2'd1;
  localparam logic [1:0] STAT_OFF    = 2'd2;
  localparam logic [1:0] STAT_BEHIND = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIN_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COS_C = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VDIST = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd7;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [7:0]       point_x;
    logic signed [7:0]       point_y;
    logic signed [7:0]       point_z;
    logic [GLYPH_W-1:0]      glyph;
    logic [CELL_FIELD_W-1:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [CELL_FIELD_W-1:0] target_cell;
    logic [GLYPH_W-1:0]      glyph_out;
    logic [DEPTH_W-1:0]      depth_out;
    logic [1:0]              status;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ROT,
    S_DIVINIT,
    S_DIV,
    S_PROJ,
    S_SCREEN,
    S_READ,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROT,
    OP_DIVINIT,
    OP_DIV,
    OP_PROJ,
    OP_SCREEN,
    OP_READ,
    OP_UPDATE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       cell_ok;
    logic       behind;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/rotate_project_zbuffer_plot.sv =====
// Plot unit top level: one request at a time. A plot goes from accept through
// 16 rotation multiplies on one shared multiplier, 24 divider bit steps,
// 3 projection multiplies, screen map, store read and update; a point behind the viewer
// ends after the divider setup. Next request is taken the cycle after the result
// is queued. Reset clears control and config registers; the cell store is not cleared.
`default_nettype none
module rotate_project_zbuffer_plot #(
  parameter int COLUMNS = 160,
  parameter int ROWS    = 44
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rpz_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rpz_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire rpz_pkg::in_t                   in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output rpz_pkg::out_t                       out_data_o
);
  import rpz_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rpz_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpz_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // one word in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a word while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_BEHIND |->
      out_data_o.target_cell == '0 && out_data_o.glyph_out == '0 &&
      out_data_o.depth_out == '0)
    else $error("behind result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_OFF |->
      out_data_o.target_cell == '0 && out_data_o.depth_out == '0)
    else $error("off-screen result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_UPDATE |-> !out_valid_o || out_ready_i)
    else $error("result overwritten before taken");

endmodule
`default_nettype wire

// ===== design/rpz_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rpz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 7040
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/rpz_ctrl.sv =====
// Sequencer for the plot unit: steps the datapath through rotation,
// divide, projection and cell update. Depends on rpz_pkg.
`default_nettype none
module rpz_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  input  wire rpz_pkg::sts_t sts_i,
  output rpz_pkg::cmd_t      cmd_o
);
  import rpz_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = cnt_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.mode)
          MODE_PLOT: begin
            state_d = S_ROT;
            cnt_d   = '0;
          end
          MODE_CLEAR, MODE_READ: state_d = sts_i.cell_ok ? S_READ : S_FINISH;
          default:               state_d = S_FINISH;
        endcase
      end
      S_ROT: begin
        cmd_o.op = OP_ROT;
        if (cnt_q == CNT_W'(ROT_STEPS - 1)) begin
          state_d = S_DIVINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIVINIT: begin
        cmd_o.op = OP_DIVINIT;
        if (sts_i.behind) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_DIV;
          cnt_d   = CNT_W'(DIV_BITS - 1);
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (cnt_q == '0) begin
          state_d = S_PROJ;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_PROJ: begin
        cmd_o.op = OP_PROJ;
        if (cnt_q == CNT_W'(PROJ_STEPS - 1)) begin
          state_d = S_SCREEN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SCREEN: begin
        cmd_o.op = OP_SCREEN;
        state_d  = S_READ;
      end
      S_READ: begin
        cmd_o.op = OP_READ;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_UPDATE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (cmd_o.op == OP_UPDATE) || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== design/rpz_dp.sv =====
// Datapath of the plot unit: config registers, shared multiplier,
// restoring divider, screen mapping and the cell store. Depends on rpz_pkg, rpz_ram.
`default_nettype none
module rpz_dp #(
  parameter int COLUMNS = 160,
  parameter int ROWS    = 44
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rpz_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [rpz_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire rpz_pkg::in_t                       in_data_i,
  input  wire rpz_pkg::cmd_t                      cmd_i,
  output rpz_pkg::sts_t                           sts_o,
  output rpz_pkg::out_t                           out_data_o
);
  import rpz_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int NQ_W   = $clog2(3 * COLUMNS);
  localparam int MEM_W  = GLYPH_W + DEPTH_W;
  localparam logic signed [63:0] ColBase  = 64'(COLUMNS) <<< 31;
  localparam logic signed [63:0] RowBase  = 64'(ROWS / 2) <<< 30;
  localparam logic signed [63:0] ColLimit = 64'(3 * COLUMNS);
  localparam logic signed [63:0] RowLimit = 64'(ROWS);
  localparam logic signed [63:0] ColNeg   = -(64'sd3 <<< 30);
  localparam logic signed [63:0] RowNeg   = -(64'sd1 <<< 30);
  localparam logic signed [63:0] SatLimit = 64'sd1 <<< 20;

  // configuration
  logic signed [15:0] sa_q, ca_q, sb_q, cb_q, sc_q, cc_q;
  logic [9:0]         vd_q;
  logic [7:0]         scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q    <= 16'sd0;
      ca_q    <= 16'sd16384;
      sb_q    <= 16'sd0;
      cb_q    <= 16'sd16384;
      sc_q    <= 16'sd0;
      cc_q    <= 16'sd16384;
      vd_q    <= 10'd80;
      scale_q <= 8'd40;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIN_A: sa_q    <= cfg_data_i;
        REG_COS_A: ca_q    <= cfg_data_i;
        REG_SIN_B: sb_q    <= cfg_data_i;
        REG_COS_B: cb_q    <= cfg_data_i;
        REG_SIN_C: sc_q    <= cfg_data_i;
        REG_COS_C: cc_q    <= cfg_data_i;
        REG_VDIST: vd_q    <= cfg_data_i[9:0];
        REG_SCALE: scale_q <= cfg_data_i[7:0];
        default:   ;
      endcase
    end
  end

  // working registers
  in_t                in_q;
  logic               cell_ok_q, behind_q, sat_q, off_q;
  logic signed [24:0] u_q, v_q;
  logic signed [31:0] tsbcc_q, tsbsc_q, tcbcc_q, tcbsc_q;
  logic signed [63:0] x_q, y_q, z_q, px_q, py_q;
  logic [63:0]        rem_q;
  logic [DIV_BITS-1:0] quo_q;
  logic signed [33:0] sinv_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [CELL_W-1:0]  cell_q;
  out_t               out_q;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [61:0] mul_p;
  logic signed [63:0] p64;
  logic [DEPTH_W-1:0] inv;
  logic signed [27:0] xq, yq;

  assign inv = sat_q ? '1 : quo_q;
  assign xq  = 28'(x_q >>> 28);
  assign yq  = 28'(y_q >>> 28);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == OP_ROT) begin
      case (cmd_i.idx)
        5'd0:    begin mul_a = 34'(in_q.point_y); mul_b = 28'(sa_q); end
        5'd1:    begin mul_a = 34'(in_q.point_z); mul_b = 28'(ca_q); end
        5'd2:    begin mul_a = 34'(in_q.point_y); mul_b = 28'(ca_q); end
        5'd3:    begin mul_a = 34'(in_q.point_z); mul_b = 28'(sa_q); end
        5'd4:    begin mul_a = 34'(sb_q);         mul_b = 28'(cc_q); end
        5'd5:    begin mul_a = 34'(sb_q);         mul_b = 28'(sc_q); end
        5'd6:    begin mul_a = 34'(cb_q);         mul_b = 28'(cc_q); end
        5'd7:    begin mul_a = 34'(cb_q);         mul_b = 28'(sc_q); end
        5'd8:    begin mul_a = 34'(tsbcc_q);      mul_b = 28'(u_q); end
        5'd9:    begin mul_a = 34'(sc_q);         mul_b = 28'(v_q); end
        5'd10:   begin mul_a = 34'(tcbcc_q);      mul_b = 28'(in_q.point_x); end
        5'd11:   begin mul_a = 34'(cc_q);         mul_b = 28'(v_q); end
        5'd12:   begin mul_a = 34'(tcbsc_q);      mul_b = 28'(in_q.point_x); end
        5'd13:   begin mul_a = 34'(tsbsc_q);      mul_b = 28'(u_q); end
        5'd14:   begin mul_a = 34'(cb_q);         mul_b = 28'(u_q); end
        5'd15:   begin mul_a = 34'(sb_q);         mul_b = 28'(in_q.point_x); end
        default: ;
      endcase
    end else if (cmd_i.op == OP_PROJ) begin
      case (cmd_i.idx)
        5'd0:    begin mul_a = 34'(inv); mul_b = 28'(scale_q); end
        5'd1:    begin mul_a = sinv_q;   mul_b = xq; end
        5'd2:    begin mul_a = sinv_q;   mul_b = yq; end
        default: ;
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;
  assign p64   = 64'(mul_p);

  // divider trial
  logic [63:0] trial;
  assign trial = 64'(z_q) << cmd_i.idx;

  // screen mapping
  logic signed [63:0] n_sum, m_sum, nq, mq;
  logic               col_on, row_on;
  logic [NQ_W+16:0]   cdiv;
  logic [COL_W-1:0]   col_val;
  logic [ROW_W-1:0]   row_val;

  always_comb begin
    n_sum = ColBase + (px_q <<< 2) + (px_q <<< 1);
    m_sum = RowBase + py_q;
    nq    = n_sum >>> 30;
    mq    = m_sum >>> 30;
    // divide by 3 through the reciprocal, exact over this range
    cdiv  = (NQ_W+17)'(nq[NQ_W-1:0]) * (NQ_W+17)'(17'd43691);
    if (n_sum < 0) begin
      col_on  = (n_sum > ColNeg);
      col_val = '0;
    end else begin
      col_on  = (nq < ColLimit);
      col_val = COL_W'(cdiv >> 17);
    end
    if (m_sum < 0) begin
      row_on  = (m_sum > RowNeg);
      row_val = '0;
    end else begin
      row_on  = (mq < RowLimit);
      row_val = ROW_W'(mq);
    end
  end

  // cell store
  logic [CELL_W-1:0]  rd_addr, ram_addr;
  logic [MEM_W-1:0]   ram_wdata, ram_rdata;
  logic               ram_we;
  logic [GLYPH_W-1:0] rd_glyph;
  logic [DEPTH_W-1:0] rd_depth;
  out_t               res;

  assign rd_addr  = (in_q.mode == MODE_PLOT)
                  ? CELL_W'(32'(col_q) + 32'(row_q) * COLUMNS)
                  : CELL_W'(in_q.cell_index);
  assign ram_addr = (cmd_i.op == OP_READ) ? rd_addr : cell_q;
  assign rd_glyph = ram_rdata[MEM_W-1:DEPTH_W];
  assign rd_depth = ram_rdata[DEPTH_W-1:0];

  always_comb begin
    res       = '0;
    ram_we    = 1'b0;
    ram_wdata = {in_q.glyph, DEPTH_W'(0)};
    case (in_q.mode)
      MODE_PLOT: begin
        if (behind_q) begin
          res.status = STAT_BEHIND;
        end else if (off_q) begin
          res.status = STAT_OFF;
        end else if (inv > rd_depth) begin
          ram_we    = 1'b1;
          ram_wdata = {in_q.glyph, inv};
          res       = '{CELL_FIELD_W'(cell_q), in_q.glyph, inv, STAT_DONE};
        end else begin
          res = '{CELL_FIELD_W'(cell_q), rd_glyph, rd_depth, STAT_HIDDEN};
        end
      end
      MODE_CLEAR: begin
        if (!cell_ok_q) begin
          res.status = STAT_OFF;
        end else begin
          ram_we = 1'b1;
          res    = '{CELL_FIELD_W'(cell_q), in_q.glyph, DEPTH_W'(0), STAT_DONE};
        end
      end
      MODE_READ: begin
        if (!cell_ok_q) begin
          res.status = STAT_OFF;
        end else begin
          res = '{CELL_FIELD_W'(cell_q), rd_glyph, rd_depth, STAT_DONE};
        end
      end
      default: ;
    endcase
    if (cmd_i.op != OP_UPDATE) begin
      ram_we = 1'b0;
    end
  end

  rpz_ram #(
    .WIDTH (MEM_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.op == OP_READ),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        in_q      <= in_data_i;
        cell_ok_q <= (32'(in_data_i.cell_index) < CELLS);
      end
      OP_ROT: begin
        case (cmd_i.idx)
          5'd0:    u_q     <= 25'(mul_p);
          5'd1:    u_q     <= u_q - 25'(mul_p);
          5'd2:    v_q     <= 25'(mul_p);
          5'd3:    v_q     <= v_q + 25'(mul_p);
          5'd4:    tsbcc_q <= 32'(mul_p);
          5'd5:    tsbsc_q <= 32'(mul_p);
          5'd6:    tcbcc_q <= 32'(mul_p);
          5'd7:    tcbsc_q <= 32'(mul_p);
          5'd8:    x_q     <= p64;
          5'd9:    x_q     <= x_q + (p64 <<< 14);
          5'd10:   x_q     <= x_q + (p64 <<< 14);
          5'd11:   y_q     <= p64 <<< 14;
          5'd12:   y_q     <= y_q - (p64 <<< 14);
          5'd13:   y_q     <= y_q - p64;
          5'd14:   z_q     <= (64'(vd_q) <<< 28) - p64;
          5'd15:   z_q     <= z_q + (p64 <<< 14);
          default: ;
        endcase
      end
      OP_DIVINIT: begin
        behind_q <= (z_q <= 64'sd0);
        sat_q    <= (z_q <= SatLimit);
        rem_q    <= 64'd1 << 44;
        quo_q    <= '0;
      end
      OP_DIV: begin
        if (rem_q >= trial) begin
          rem_q                <= rem_q - trial;
          quo_q[cmd_i.idx]     <= 1'b1;
        end
      end
      OP_PROJ: begin
        case (cmd_i.idx)
          5'd0:    sinv_q <= 34'(mul_p);
          5'd1:    px_q   <= p64;
          5'd2:    py_q   <= p64;
          default: ;
        endcase
      end
      OP_SCREEN: begin
        off_q <= !(col_on && row_on);
        col_q <= col_val;
        row_q <= row_val;
      end
      OP_READ: cell_q <= rd_addr;
      OP_UPDATE: out_q <= res;
      default: ;
    endcase
  end

  assign sts_o.mode    = in_q.mode;
  assign sts_o.cell_ok = cell_ok_q;
  assign sts_o.behind  = (z_q <= 64'sd0);
  assign out_data_o    = out_q;

endmodule
`default_nettype wire
